// ===== hdl/apet_pkg.sv =====
package apet_pkg;

  // Field widths
  localparam int SAMPLE_BITS   = 24;
  localparam int POSITION_BITS = 48;
  localparam int LEVEL_BITS    = 24;
  localparam int CFG_IDX_BITS  = 1;

  typedef logic [LEVEL_BITS-1:0]    level_t;
  typedef logic [POSITION_BITS-1:0] position_t;

  // Item kinds
  localparam logic KIND_SAMPLE    = 1'b0;
  localparam logic KIND_BLOCK_END = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_ATTACK  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE = 1'b1;

  // Register reset values: about -1 dBFS and -2 dBFS
  localparam level_t ATTACK_RESET  = 24'd7476317;
  localparam level_t RELEASE_RESET = 24'd6663271;

  typedef struct packed {
    logic                           kind;
    logic signed [SAMPLE_BITS-1:0]  sample;
    position_t                      position;
    logic                           detect;
    logic                           monitor;
    logic                           capture_start;
  } in_item_t;

  typedef struct packed {
    position_t mark_position;
    level_t    mark_peak;
    logic      mark_monitor;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_BITS-1:0] reg_index;
    level_t                  data;
  } cfg_item_t;

  // Detector status toward the output stage
  typedef struct packed {
    logic      emit;
    out_item_t mark;
  } det_t;

endpackage

// ===== hdl/apet_ifs.sv =====
interface apet_in_if;
  import apet_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface apet_out_if;
  import apet_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface apet_cfg_if;
  import apet_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== hdl/audio_peak_event_tagger.sv =====
// A mark is registered in the output register when the block-end item closing its event
// leaves the input register. Throughput: one item per cycle; while a mark waits, only a
// block end that closes another event stalls the input until that mark is taken.
// Configuration writes are registered and always ready.
// Reset (rst, synchronous): levels return to -1 dBFS / -2 dBFS defaults,
// block peak and event state clear, both pipeline stages empty.
module audio_peak_event_tagger (
  input logic       clk,
  input logic       rst,
  apet_in_if.sink   samples,
  apet_out_if.source marks,
  apet_cfg_if.sink  cfg
);
  import apet_pkg::*;

  level_t    attack_level;
  level_t    release_level;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_adv;
  det_t      det;
  logic      out_valid;
  out_item_t out_item;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_level  <= ATTACK_RESET;
      release_level <= RELEASE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.item.reg_index)
        CFG_ATTACK:  attack_level  <= cfg.item.data;
        CFG_RELEASE: release_level <= cfg.item.data;
        default: ;
      endcase
    end
  end

  // Stage 1 moves on unless it emits into a full, stalled output register
  assign s1_adv        = s1_valid && (!det.emit || !out_valid || marks.ready);
  assign samples.ready = !s1_valid || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst)
      s1_valid <= 1'b0;
    else if (samples.ready)
      s1_valid <= samples.valid;
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready)
      s1_item <= samples.item;
  end

  apet_detect u_detect (
    .clk           (clk),
    .rst           (rst),
    .step          (s1_adv),
    .item          (s1_item),
    .attack_level  (attack_level),
    .release_level (release_level),
    .det           (det)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (s1_adv && det.emit)
      out_valid <= 1'b1;
    else if (marks.ready)
      out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s1_adv && det.emit)
      out_item <= det.mark;
  end

  assign marks.valid = out_valid;
  assign marks.item  = out_item;

  a_emit_on_block_end: assert property (@(posedge clk) disable iff (rst)
    s1_valid && det.emit |-> s1_item.kind == KIND_BLOCK_END)
    else $error("mark raised by an audio item");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_adv && det.emit))
    else $error("mark appeared without an emit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    s1_adv && det.emit |-> !out_valid || marks.ready)
    else $error("pending mark overwritten");

endmodule

// ===== hdl/apet_detect.sv =====
module apet_detect (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  apet_pkg::in_item_t item,
  input  apet_pkg::level_t  attack_level,
  input  apet_pkg::level_t  release_level,
  output apet_pkg::det_t    det
);
  import apet_pkg::*;

  level_t    block_max;
  logic      event_open;
  level_t    event_peak;
  position_t held_position;
  logic      held_monitor;

  level_t    mag;
  logic      open_eff;
  logic      above_attack;
  logic      take_mark;
  logic      emit;

  // Magnitude; the most negative sample wraps to exactly full scale
  assign mag = item.sample[SAMPLE_BITS-1] ? level_t'(~item.sample + 1'b1)
                                          : level_t'(item.sample);

  // Hysteresis decision for a block-end item
  always_comb begin
    open_eff     = event_open && !item.capture_start;
    above_attack = block_max >= attack_level;
    take_mark    = item.detect && above_attack && (!open_eff || block_max > event_peak);
    emit         = 1'b0;
    if (item.kind == KIND_BLOCK_END && open_eff) begin
      if (!item.detect)
        emit = 1'b1;
      else if (!above_attack && block_max < release_level)
        emit = 1'b1;
    end
  end

  assign det.emit               = emit;
  assign det.mark.mark_position = held_position;
  assign det.mark.mark_peak     = event_peak;
  assign det.mark.mark_monitor  = held_monitor;

  // State update per item
  always_ff @(posedge clk) begin
    if (rst) begin
      block_max     <= '0;
      event_open    <= 1'b0;
      event_peak    <= '0;
      held_position <= '0;
      held_monitor  <= 1'b0;
    end else if (step) begin
      if (item.kind == KIND_SAMPLE) begin
        if (mag > block_max)
          block_max <= mag;
      end else begin
        block_max <= '0;
        if (take_mark) begin
          event_open    <= 1'b1;
          event_peak    <= block_max;
          held_position <= item.position;
          held_monitor  <= item.monitor;
        end else if (emit) begin
          event_open <= 1'b0;
        end else begin
          event_open <= open_eff && item.detect;
        end
      end
    end
  end

  a_emit_closes: assert property (@(posedge clk) disable iff (rst)
    step && emit |=> !event_open)
    else $error("event still open after emit");

  a_block_clear: assert property (@(posedge clk) disable iff (rst)
    step && item.kind == KIND_BLOCK_END |=> block_max == '0)
    else $error("block peak not cleared at block end");

  a_emit_needs_open: assert property (@(posedge clk) disable iff (rst)
    emit |-> event_open)
    else $error("emit with no open event");

  a_mark_held: assert property (@(posedge clk) disable iff (rst)
    step && item.kind == KIND_SAMPLE |=> $stable(event_peak) && $stable(held_position))
    else $error("held mark moved on an audio item");

endmodule
